// ----- rtl/core/b64d_pkg.sv -----
// Package for the base64url stream decoder: character codes, word types
// shared by the classifier, the queues and the decode engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned ACC_W    = 12;
    localparam int unsigned PEND_W   = 4;

    localparam int unsigned CMD_QUEUE_DEPTH = 2;
    localparam int unsigned RES_QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_UNDER   = 8'h5F;
    localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_PAD     = 8'h3D;

    localparam logic [SEXTET_W-1:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [SEXTET_W-1:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [SEXTET_W-1:0] SEXTET_62         = 6'd62;
    localparam logic [SEXTET_W-1:0] SEXTET_63         = 6'd63;

    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_SEXTET,
        KIND_PAD
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [SEXTET_W-1:0] sextet;
        logic                eos;
    } t_cls_word;

    typedef struct packed {
        logic [CHAR_W-1:0] byte_out;
        logic              byte_valid;
        logic              last;
    } t_res_word;

    typedef struct packed {
        logic [PEND_W-1:0] pending_bits;
        logic              pad_seen;
    } t_back_status;

endpackage

`default_nettype wire

// ----- rtl/core/base64url_stream_decoder.sv -----
// Base64url / base64 stream decoder, one character word in, zero or one
// decoded byte word out. Depends on b64d_pkg, b64d_front, b64d_back, b64d_queue.
//
// Usage:
//   Input channel: drive i_char_code and i_end_of_string with i_push high; the
//   word is taken on a clock edge where o_full is low. Characters outside the
//   alphabet are dropped, '=' ends decoding for the rest of the string.
//   Result channel: while o_empty is low, o_byte_out / o_byte_valid /
//   o_last_result show the oldest result; i_pop takes it.
//   Every complete byte is one result;
//   the character marked end_of_string always gives exactly one result with
//   o_last_result set, o_byte_valid possibly 0.
// Timing:
//   One character word per cycle, sustained, while o_full is low. A word passes the classifier into
//   a two-entry command queue, the decode engine retires one command per cycle
//   while the result queue has room, into a two-entry result queue.
//   When the receiver stalls, the result queue fills, then the command queue,
//   and o_full rises; nothing is dropped.
// Reset: synchronous, active low; clears both queues and the decode state.
`timescale 1ns / 1ps
`default_nettype none

module base64url_stream_decoder
    import b64d_pkg::*;
#(
    parameter int unsigned CMD_DEPTH = CMD_QUEUE_DEPTH,
    parameter int unsigned RES_DEPTH = RES_QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic              i_end_of_string,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic      [CHAR_W-1:0] o_byte_out,
    output logic                   o_byte_valid,
    output logic                   o_last_result
);

    t_cls_word    cls_word;
    t_cls_word    cmd_word;
    logic         cmd_empty;
    logic         cmd_pop;
    t_res_word    res_in;
    t_res_word    res_out;
    logic         res_push;
    logic         res_full;
    t_back_status back_status;

    b64d_front u_front (
        .i_char_code     (i_char_code),
        .i_end_of_string (i_end_of_string),
        .o_word          (cls_word)
    );

    b64d_queue #(
        .WIDTH ($bits(t_cls_word)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls_word),
        .o_full  (o_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_word),
        .o_empty (cmd_empty)
    );

    b64d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_word),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .o_status    (back_status)
    );

    b64d_queue #(
        .WIDTH ($bits(t_res_word)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (res_out),
        .o_empty (o_empty)
    );

    assign o_byte_out    = res_out.byte_out;
    assign o_byte_valid  = res_out.byte_valid;
    assign o_last_result = res_out.last;

`ifndef SYNTHESIS
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_pending_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.pending_bits == 4'd0 || back_status.pending_bits == 4'd2 ||
        back_status.pending_bits == 4'd4 || back_status.pending_bits == 4'd6)
        else $error("pending bit count out of range");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_accept_reaches_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> !cmd_empty)
        else $error("accepted word missing from command queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/b64d_queue.sv -----
// Small register FIFO used between the classifier and the decode engine and
// on the result side. Depends on nothing; width and depth are parameters.
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/b64d_front.sv -----
// Front end: maps one input character to a sextet, pad mark or skip.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_front
    import b64d_pkg::*;
(
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic              i_end_of_string,
    output t_cls_word              o_word
);

    logic [CHAR_W-1:0] offs;

    always_comb begin
        o_word.kind   = KIND_SKIP;
        o_word.sextet = '0;
        o_word.eos    = i_end_of_string;
        offs          = '0;
        if (i_char_code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            offs          = i_char_code - CHAR_UPPER_A;
            o_word.kind   = KIND_SEXTET;
            o_word.sextet = offs[SEXTET_W-1:0];
        end else if (i_char_code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            offs          = i_char_code - CHAR_LOWER_A;
            o_word.kind   = KIND_SEXTET;
            o_word.sextet = offs[SEXTET_W-1:0] + SEXTET_LOWER_BASE;
        end else if (i_char_code inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
            offs          = i_char_code - CHAR_DIGIT_0;
            o_word.kind   = KIND_SEXTET;
            o_word.sextet = offs[SEXTET_W-1:0] + SEXTET_DIGIT_BASE;
        end else if (i_char_code inside {CHAR_DASH, CHAR_PLUS}) begin
            o_word.kind   = KIND_SEXTET;
            o_word.sextet = SEXTET_62;
        end else if (i_char_code inside {CHAR_UNDER, CHAR_SLASH}) begin
            o_word.kind   = KIND_SEXTET;
            o_word.sextet = SEXTET_63;
        end else if (i_char_code == CHAR_PAD) begin
            o_word.kind   = KIND_PAD;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/b64d_back.sv -----
// Back end: bit accumulator, byte extraction and end-of-string handling.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_back
    import b64d_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cls_word    i_cmd,
    input  wire logic         i_cmd_valid,
    output logic              o_cmd_pop,
    input  wire logic         i_res_full,
    output logic              o_res_push,
    output t_res_word         o_res,
    output t_back_status      o_status
);

    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic              r_pad, n_pad;
    logic [PEND_W:0]   p_sum;
    logic [PEND_W-1:0] p_sat;
    logic [ACC_W-1:0]  acc_shift;
    logic [ACC_W-1:0]  shifted;
    logic [2:0]        sh_amt;
    logic              have_byte;
    logic [CHAR_W-1:0] byte_val;

    assign o_cmd_pop = i_cmd_valid && !i_res_full;
    assign o_status  = '{pending_bits: r_pend, pad_seen: r_pad};

    always_comb begin
        acc_shift = {r_acc[ACC_W-SEXTET_W-1:0], i_cmd.sextet};
        p_sum     = {1'b0, r_pend} + (PEND_W+1)'(SEXTET_W);
        p_sat     = (p_sum > (PEND_W+1)'(ACC_W)) ? PEND_W'(ACC_W) : p_sum[PEND_W-1:0];
        sh_amt    = 3'(p_sat - PEND_W'(CHAR_W));
        shifted   = acc_shift >> sh_amt;
        have_byte = 1'b0;
        byte_val  = '0;
        n_acc     = r_acc;
        n_pend    = r_pend;
        n_pad     = r_pad;
        if (o_cmd_pop && !r_pad) begin
            case (i_cmd.kind)
                KIND_PAD: begin
                    n_pad = 1'b1;
                end
                KIND_SEXTET: begin
                    n_acc = acc_shift;
                    if (p_sat >= PEND_W'(CHAR_W)) begin
                        have_byte = 1'b1;
                        byte_val  = shifted[CHAR_W-1:0];
                        n_pend    = p_sat - PEND_W'(CHAR_W);
                    end else begin
                        n_pend    = p_sat;
                    end
                end
                default: begin
                end
            endcase
        end
        if (o_cmd_pop && i_cmd.eos) begin
            n_acc  = '0;
            n_pend = '0;
            n_pad  = 1'b0;
        end
    end

    always_comb begin
        o_res_push       = o_cmd_pop && (have_byte || i_cmd.eos);
        o_res.byte_out   = byte_val;
        o_res.byte_valid = have_byte;
        o_res.last       = i_cmd.eos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pend <= '0;
            r_pad  <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
            r_pad  <= n_pad;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/b64d_decode_checker.sv -----
// Result checker for base64url_stream_decoder: tracks the decode state from the
// accepted character words and compares every popped result word in order.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_decode_checker
    import b64d_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic              i_full,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic              i_end_of_string,
    input  wire logic              i_pop,
    input  wire logic              i_empty,
    input  wire logic [CHAR_W-1:0] i_byte_out,
    input  wire logic              i_byte_valid,
    input  wire logic              i_last_result,
    output int                     o_fail_count,
    output int                     o_outstanding,
    output int                     o_results_seen,
    output int                     o_strings_closed
);

    logic [ACC_W-1:0]  acc_q;
    logic [PEND_W-1:0] pend_q;
    logic              pad_q;
    t_res_word         expected_words[$];

    function automatic t_kind classify(input logic [CHAR_W-1:0] c,
                                       output logic [SEXTET_W-1:0] sx);
        sx = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            sx = SEXTET_W'(c - CHAR_UPPER_A);
            return KIND_SEXTET;
        end
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            sx = SEXTET_W'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
            return KIND_SEXTET;
        end
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            sx = SEXTET_W'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
            return KIND_SEXTET;
        end
        if (c == CHAR_DASH || c == CHAR_PLUS) begin
            sx = SEXTET_62;
            return KIND_SEXTET;
        end
        if (c == CHAR_UNDER || c == CHAR_SLASH) begin
            sx = SEXTET_63;
            return KIND_SEXTET;
        end
        if (c == CHAR_PAD) return KIND_PAD;
        return KIND_SKIP;
    endfunction

    task automatic decode_char(input logic [CHAR_W-1:0] c, input logic eos);
        t_kind               kind;
        logic [SEXTET_W-1:0] sx;
        logic [ACC_W-1:0]    shifted;
        int unsigned         bits;
        logic                got;
        logic [CHAR_W-1:0]   b;
        t_res_word           w;
        got = 1'b0;
        b   = '0;
        if (!pad_q) begin
            kind = classify(c, sx);
            if (kind == KIND_PAD) begin
                pad_q = 1'b1;
            end else if (kind == KIND_SEXTET) begin
                acc_q = {acc_q[ACC_W-SEXTET_W-1:0], sx};
                bits  = pend_q + SEXTET_W;
                if (bits > ACC_W) bits = ACC_W;
                if (bits >= CHAR_W) begin
                    shifted = acc_q >> (bits - CHAR_W);
                    b       = shifted[CHAR_W-1:0];
                    got     = 1'b1;
                    bits    = bits - CHAR_W;
                end
                pend_q = bits[PEND_W-1:0];
            end
        end
        if (eos || got) begin
            w.byte_out   = got ? b : '0;
            w.byte_valid = got;
            w.last       = eos;
            expected_words = {expected_words, w};
        end
        if (eos) begin
            acc_q  = '0;
            pend_q = '0;
            pad_q  = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_res_word w;
        if (!i_rst_n) begin
            acc_q  = '0;
            pend_q = '0;
            pad_q  = 1'b0;
            expected_words.delete();
            o_fail_count     = 0;
            o_results_seen   = 0;
            o_strings_closed = 0;
        end else begin
            if (i_pop && !i_empty) begin
                o_results_seen = o_results_seen + 1;
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: byte_out=%02h byte_valid=%0b last=%0b",
                           i_byte_out, i_byte_valid, i_last_result);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    w = expected_words.pop_front();
                    if (i_byte_out !== w.byte_out) begin
                        $error("byte_out: expected %02h, got %02h", w.byte_out, i_byte_out);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_byte_valid !== w.byte_valid) begin
                        $error("byte_valid: expected %0b, got %0b", w.byte_valid, i_byte_valid);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_last_result !== w.last) begin
                        $error("last_result: expected %0b, got %0b", w.last, i_last_result);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (w.last) o_strings_closed = o_strings_closed + 1;
                end
            end
            if (i_push && !i_full) decode_char(i_char_code, i_end_of_string);
        end
        o_outstanding <= expected_words.size();
    end

endmodule

// ----- tb/sv/tb_base64url_stream_decoder.sv -----
// Testbench top for base64url_stream_decoder: drives character strings and
// random result pops, then reports the verdict from b64d_decode_checker.
// Depends on b64d_pkg, base64url_stream_decoder and b64d_decode_checker.
`timescale 1ns / 1ps

module tb_base64url_stream_decoder;
    import b64d_pkg::*;

    localparam int NUM_CHARS  = 1700;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 200;
    localparam int DRAIN_WAIT = 20;

    logic              i_clk;
    logic              i_rst_n         = 1'b0;
    logic              i_push          = 1'b0;
    logic [CHAR_W-1:0] i_char_code     = '0;
    logic              i_end_of_string = 1'b0;
    logic              i_pop           = 1'b0;
    logic              o_full;
    logic              o_empty;
    logic [CHAR_W-1:0] o_byte_out;
    logic              o_byte_valid;
    logic              o_last_result;

    int fail_count;
    int outstanding;
    int results_seen;
    int strings_closed;

    int   chars_sent  = 0;
    logic hold_active = 1'b0;
    logic no_gaps     = 1'b0;
    logic [CHAR_W-1:0] str_q[$];

    base64url_stream_decoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_char_code    (i_char_code),
        .i_end_of_string(i_end_of_string),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_byte_out     (o_byte_out),
        .o_byte_valid   (o_byte_valid),
        .o_last_result  (o_last_result)
    );

    b64d_decode_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_full          (o_full),
        .i_char_code     (i_char_code),
        .i_end_of_string (i_end_of_string),
        .i_pop           (i_pop),
        .i_empty         (o_empty),
        .i_byte_out      (o_byte_out),
        .i_byte_valid    (o_byte_valid),
        .i_last_result   (o_last_result),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_results_seen  (results_seen),
        .o_strings_closed(strings_closed)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (hold_active || no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] sextet_char(input int unsigned v);
        if (v < 26) return CHAR_UPPER_A + CHAR_W'(v);
        if (v < 52) return CHAR_LOWER_A + CHAR_W'(v - 26);
        if (v < 62) return CHAR_DIGIT_0 + CHAR_W'(v - 52);
        if (v == 62) return $urandom_range(0, 1) ? CHAR_DASH : CHAR_PLUS;
        return $urandom_range(0, 1) ? CHAR_UNDER : CHAR_SLASH;
    endfunction

    task automatic append_char(input logic [CHAR_W-1:0] c);
        str_q = {str_q, c};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) append_char(s[i]);
    endtask

    // push one word, wait for the accepting edge, then idle a random gap
    task automatic send_string();
        int gap;
        for (int i = 0; i < str_q.size(); i++) begin
            i_char_code     <= str_q[i];
            i_end_of_string <= (i == str_q.size() - 1);
            i_push          <= 1'b1;
            @(posedge i_clk);
            while (o_full) @(posedge i_clk);
            chars_sent++;
            gap = pick_gap();
            if (gap > 0) begin
                i_push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        str_q.delete();
    endtask

    task automatic build_random_string();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            len = $urandom_range(1, 16);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) append_char(CHAR_W'($urandom_range(0, 255)));
                append_char(sextet_char($urandom_range(0, 63)));
            end
            if ($urandom_range(0, 3) == 0) begin
                append_char(CHAR_PAD);
                if ($urandom_range(0, 1)) append_char(CHAR_PAD);
                if ($urandom_range(0, 2) == 0) begin
                    append_char(sextet_char($urandom_range(0, 63)));
                    append_char(sextet_char($urandom_range(0, 63)));
                end
            end
        end else if (kind < 85) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) append_char(CHAR_W'($urandom_range(0, 255)));
        end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 2) == 0) append_char(CHAR_PAD);
                else append_char(sextet_char($urandom_range(0, 63)));
            end
        end
    endtask

    // receiver: random stalls plus one long hold-off to back up the input side
    initial begin : receiver
        int stall_left;
        logic hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!hold_done && chars_sent >= HOLD_AT) begin
                hold_done   = 1'b1;
                hold_active = 1'b1;
                i_pop      <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_active = 1'b0;
            end else if (stall_left > 0) begin
                i_pop <= 1'b0;
                stall_left--;
            end else begin
                i_pop <= 1'b1;
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 9) < 8) stall_left = $urandom_range(1, 3);
                    else stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_text("TWFu");
        send_string();
        add_text("AZaz09");
        append_char(CHAR_DASH);
        append_char(CHAR_PLUS);
        append_char(CHAR_UNDER);
        append_char(CHAR_SLASH);
        send_string();
        // junk mid-string, padding, characters after the pad, junk at the end
        add_text("Q");
        append_char(8'h00);
        add_text("Q");
        append_char(CHAR_PAD);
        add_text("AA");
        append_char(8'hFF);
        send_string();
        append_char(8'h7F);
        send_string();
        append_char(CHAR_PAD);
        send_string();

        while (chars_sent < NUM_CHARS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            build_random_string();
            send_string();
        end
        i_push <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d characters; checked %0d result words closing %0d strings.",
                 chars_sent, results_seen, strings_closed);
        $display("Receiver held off for %0d cycles while characters kept arriving.",
                 HOLD_LEN);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/b64d_pkg.sv
rtl/core/b64d_queue.sv
rtl/core/b64d_front.sv
rtl/core/b64d_back.sv
rtl/core/base64url_stream_decoder.sv
tb/sv/b64d_decode_checker.sv
tb/sv/tb_base64url_stream_decoder.sv
